// ===== sv/imu_frame_parser_assert.svh =====
// Assertion macros shared by the frame parser.
`ifndef IMU_FRAME_PARSER_ASSERT_SVH
`define IMU_FRAME_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/imf_pkg.sv =====
package imf_pkg;

	localparam int FRAME_BYTES_DEF = 17;

	localparam logic [7:0] HEADER_BYTE = 8'h3A;
	localparam int CHECKSUM_POS = 14;
	localparam int STORE_DEPTH = 13;

	localparam logic [7:0]  SYNC_FUNC_RST = 8'd11;
	localparam logic [14:0] RATE_DB_RST   = 15'd2;

	localparam int CFG_DATA_W = 15;

	// Register indexes on the configuration port.
	localparam logic REG_SYNC_FUNC = 1'b0;
	localparam logic REG_RATE_DB   = 1'b1;

	// Input item kinds.
	localparam logic KIND_BYTE     = 1'b0;
	localparam logic KIND_SET_ZERO = 1'b1;

	// Result status codes.
	localparam logic STATUS_GOOD    = 1'b0;
	localparam logic STATUS_BAD_SUM = 1'b1;

	localparam int OUT_DATA_W = 112;

endpackage

// ===== sv/imu_frame_parser.sv =====
// Byte-serial frame parser for a heading and yaw-rate sensor. Each input item is
// either one received serial byte (tuser = 0) or a set-zero event (tuser = 1) that
// latches the heading of the last good frame as the zero offset. The parser hunts
// for the header byte 0x3A followed by the configured function byte, then collects
// the rest of a FRAME_BYTES-long frame: index, length, five little-endian signed
// 16-bit words (heading, yaw rate, acceleration x, y and z), an 8-bit additive
// checksum over the function byte up to the last acceleration byte, and tail bytes
// that are not checked. On the last byte of each frame exactly one result item is
// produced: status 0 with the raw words, the heading relative to the zero offset,
// the yaw rate forced to zero inside the deadband and the negated z acceleration;
// or status 1 with every other field zero when the checksum does not match. Each
// item is captured in an input register and handled by the frame logic when the
// output can take a result, and any result lands in an output register
// that decouples the two sides, so a new item can be taken in every cycle while
// the output is free or being drained. Configuration writes take effect at once
// and should only be made while no item is in flight.
module imu_frame_parser
	import imf_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0]            s_axis_tuser,   // [0] kind

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] frame_index, [23:8] heading_raw, [40:24] heading_relative,
	// [56:41] yaw_rate, [72:57] accel_x, [88:73] accel_y,
	// [105:89] accel_z_negated, [111:106] zero padding
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [0:0]            m_axis_tuser,   // [0] status

	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// The position counter must hold FRAME_BYTES - 1, the last byte of a frame.
	localparam int PosW = $clog2(FRAME_BYTES);
	localparam logic [PosW-1:0] PosLast  = PosW'(FRAME_BYTES - 1);
	localparam logic [PosW-1:0] PosCsum  = PosW'(CHECKSUM_POS);
	localparam logic [PosW-1:0] PosFunc  = PosW'(1);
	localparam logic [PosW-1:0] PosFirst = PosW'(2);

	// Configuration registers.
	logic [7:0]  sync_func_q;
	logic [14:0] rate_db_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_func_q <= SYNC_FUNC_RST;
			rate_db_q   <= RATE_DB_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_FUNC: sync_func_q <= cfg_data[7:0];
				REG_RATE_DB:   rate_db_q   <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Input register stage.
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       fire;

	logic       res_valid_q;

	// The handled item moves on unless a result is waiting and not being taken.
	assign advance       = !res_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser[0];
			byte_s1 <= s_axis_tdata;
		end
	end

	// Frame state. Entry 0 of the store holds the function byte; entries 1 to 12
	// hold the index, the length and the ten data bytes.
	logic [PosW-1:0] pos_q;
	logic [7:0]      sum_q;
	logic [15:0]     last_heading_q;
	logic [15:0]     zero_offset_q;
	logic [7:0]      frame_store_q [STORE_DEPTH];

	logic [PosW-1:0] pos_d;
	logic [7:0]      sum_d;
	logic            store_we;
	logic [3:0]      store_idx;
	logic            emit;

	always_comb begin
		pos_d     = pos_q;
		sum_d     = sum_q;
		store_we  = 1'b0;
		store_idx = 4'(pos_q - PosFunc);
		emit      = 1'b0;
		if (pos_q == '0) begin
			if (byte_s1 == HEADER_BYTE) begin
				pos_d = PosFunc;
			end
		end else if (pos_q == PosFunc) begin
			if (byte_s1 == sync_func_q) begin
				// The function byte opens both the store and the checksum.
				store_we  = 1'b1;
				store_idx = 4'd0;
				sum_d     = byte_s1;
				pos_d     = PosFirst;
			end else if (byte_s1 == HEADER_BYTE) begin
				pos_d = PosFunc;
			end else begin
				pos_d = '0;
			end
		end else if (pos_q < PosCsum) begin
			store_we = 1'b1;
			sum_d    = sum_q + byte_s1;
			pos_d    = pos_q + PosFunc;
		end else begin
			// Subtracting the received checksum leaves zero on a good frame.
			if (pos_q == PosCsum) begin
				sum_d = sum_q - byte_s1;
			end
			if (pos_q < PosLast) begin
				pos_d = pos_q + PosFunc;
			end else begin
				pos_d = '0;
				emit  = 1'b1;
			end
		end
	end

	logic byte_fire;
	logic set_zero_fire;
	logic good_frame;

	assign byte_fire     = fire && (kind_s1 == KIND_BYTE);
	assign set_zero_fire = fire && (kind_s1 == KIND_SET_ZERO);
	assign good_frame    = (sum_d == 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			sum_q          <= '0;
			last_heading_q <= '0;
			zero_offset_q  <= '0;
		end else begin
			if (byte_fire) begin
				pos_q <= pos_d;
				sum_q <= sum_d;
				if (emit && good_frame) begin
					last_heading_q <= {frame_store_q[4], frame_store_q[3]};
				end
			end
			if (set_zero_fire) begin
				zero_offset_q <= last_heading_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_fire && store_we) begin
			frame_store_q[store_idx] <= byte_s1;
		end
	end

	// Result computation from the completed store.
	logic signed [15:0] head;
	logic signed [15:0] rate;
	logic signed [15:0] ax;
	logic signed [15:0] ay;
	logic signed [15:0] az;
	logic signed [16:0] rate_ext;
	logic        [16:0] rate_mag;
	logic signed [15:0] rate_out;
	logic signed [16:0] head_rel;
	logic signed [16:0] az_neg;

	assign head = {frame_store_q[4],  frame_store_q[3]};
	assign rate = {frame_store_q[6],  frame_store_q[5]};
	assign ax   = {frame_store_q[8],  frame_store_q[7]};
	assign ay   = {frame_store_q[10], frame_store_q[9]};
	assign az   = {frame_store_q[12], frame_store_q[11]};

	assign rate_ext = {rate[15], rate};
	assign rate_mag = rate[15] ? 17'(-rate_ext) : 17'(rate_ext);
	assign rate_out = (rate_mag <= {2'b00, rate_db_q}) ? 16'sd0 : rate;
	assign head_rel = {head[15], head} - {zero_offset_q[15], zero_offset_q};
	assign az_neg   = -{az[15], az};

	// Output register.
	logic        res_status_q;
	logic [7:0]  res_index_q;
	logic [15:0] res_head_q;
	logic [16:0] res_head_rel_q;
	logic [15:0] res_rate_q;
	logic [15:0] res_ax_q;
	logic [15:0] res_ay_q;
	logic [16:0] res_az_neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (byte_fire && emit) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_fire && emit) begin
			if (good_frame) begin
				res_status_q   <= STATUS_GOOD;
				res_index_q    <= frame_store_q[1];
				res_head_q     <= head;
				res_head_rel_q <= head_rel;
				res_rate_q     <= rate_out;
				res_ax_q       <= ax;
				res_ay_q       <= ay;
				res_az_neg_q   <= az_neg;
			end else begin
				res_status_q   <= STATUS_BAD_SUM;
				res_index_q    <= '0;
				res_head_q     <= '0;
				res_head_rel_q <= '0;
				res_rate_q     <= '0;
				res_ax_q       <= '0;
				res_ay_q       <= '0;
				res_az_neg_q   <= '0;
			end
		end
	end

	assign m_axis_tvalid   = res_valid_q;
	assign m_axis_tuser[0] = res_status_q;
	assign m_axis_tdata    = {6'd0, res_az_neg_q, res_ay_q, res_ax_q, res_rate_q,
		res_head_rel_q, res_head_q, res_index_q};

	// Checks on the frame logic.
`include "imu_frame_parser_assert.svh"

	`IMF_ASSERT_SAME(a_bad_frame_zero, clk, arst_n, m_axis_tvalid && (m_axis_tuser[0] == STATUS_BAD_SUM), m_axis_tdata == '0, "bad-checksum result carries non-zero data")
	`IMF_ASSERT_SAME(a_pos_in_frame, clk, arst_n, 1'b1, pos_q <= PosLast, "byte position beyond frame end")
	`IMF_ASSERT_NEXT(a_last_byte_result, clk, arst_n, byte_fire && (pos_q == PosLast), m_axis_tvalid && (pos_q == '0), "last frame byte gave no result")
	`IMF_ASSERT_SAME(a_heading_on_good, clk, arst_n, !$stable(last_heading_q), m_axis_tvalid && (m_axis_tuser[0] == STATUS_GOOD), "heading latched without a good frame")

endmodule
